/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// kcl_pkg
// Types and codes of the keypad code lock.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

    localparam int PASSCODE_W = 24;
    localparam int LIMIT_W    = 4;
    localparam int DIGIT_W    = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [PASSCODE_W-1:0] PASSCODE_RESET = 24'h178509;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 4'd3;
    localparam logic [DIGIT_W-1:0]    SLOT_RESET     = 4'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PASSCODE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAILURE_LIMIT = 1'd1;

    // key event kinds
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_DIGIT  = 2'd1;
    localparam logic [1:0] KIND_SUBMIT = 2'd2;

    typedef enum logic [2:0] {
        STATUS_IGNORED = 3'd0,
        STATUS_STARTED = 3'd1,
        STATUS_DIGIT   = 3'd2,
        STATUS_FULL    = 3'd3,
        STATUS_GRANTED = 3'd4,
        STATUS_DENIED  = 3'd5,
        STATUS_LOCKOUT = 3'd6
    } status_t;

    typedef enum logic {
        LOCK_IDLE  = 1'b0,
        LOCK_ENTRY = 1'b1
    } lock_state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DIGIT_W-1:0] digit;
    } key_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [LIMIT_W-1:0] tries_left;
        logic               unlock;
        logic               alarm;
    } res_item_t;

endpackage

`default_nettype wire

/* hdl/keypad_code_lock.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock
// Code lock fed by decoded key events. A start key opens an entry, digit keys
// fill the digit slots, and a submit key compares the first slots with the
// passcode and answers granted, denied or locked out. Every key event gives
// exactly one result item. The lock takes one item per cycle; an item passes
// an input register and then the result register, which offers its result
// until it is taken. The whole update is one pass of compare and count logic
// on the lock state. A stalled result holds the input register, and with both
// registers full the key input stalls. Write passcode and failure_limit only
// while no key item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module keypad_code_lock #(
    parameter int CODE_DIGITS      = 6,
    parameter int MAX_ENTRY_DIGITS = 7
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           key_valid,
    output logic                                key_stall,
    input  wire kcl_pkg::key_item_t             key,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output kcl_pkg::res_item_t                  res,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kcl_pkg::PASSCODE_W-1:0] cfg_data
);

    import kcl_pkg::*;

    localparam int POS_W = $clog2(MAX_ENTRY_DIGITS + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_ENTRY_DIGITS);

    logic [PASSCODE_W-1:0] passcode_reg;
    logic [LIMIT_W-1:0]    failure_limit_reg;

    lock_state_t           state_reg, state_next;
    logic [POS_W-1:0]      position_reg, position_next;
    logic [LIMIT_W-1:0]    failures_reg, failures_next;
    logic [DIGIT_W-1:0]    slot_reg  [CODE_DIGITS];
    logic [DIGIT_W-1:0]    slot_next [CODE_DIGITS];
    logic [DIGIT_W-1:0]    want      [CODE_DIGITS];

    logic                  s1_valid_reg;
    key_item_t             s1_item_reg;
    logic                  res_valid_reg;
    res_item_t             res_reg, res_next;

    logic                  accept;
    logic                  advance;
    logic                  match;
    logic [POS_W-1:0]      pos_inc;
    logic                  entry_full;
    logic [LIMIT_W:0]      fail_inc;
    logic                  limit_hit;
    logic                  is_start, is_digit, is_submit;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign key_stall = s1_valid_reg && res_valid_reg && res_stall;
    assign accept    = key_valid && !key_stall;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= key;
        if (advance)
            res_reg <= res_next;
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            passcode_reg      <= PASSCODE_RESET;
            failure_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PASSCODE:      passcode_reg      <= cfg_data;
                REG_FAILURE_LIMIT: failure_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decode and compare
    // ------------------------------------------------------------------
    assign is_start   = (s1_item_reg.kind == KIND_START);
    assign is_digit   = (s1_item_reg.kind == KIND_DIGIT);
    assign is_submit  = (s1_item_reg.kind == KIND_SUBMIT);
    assign pos_inc    = position_reg + POS_W'(1);
    assign entry_full = (pos_inc >= MAX_POS);
    assign fail_inc   = {1'b0, failures_reg} + (LIMIT_W+1)'(1);
    assign limit_hit  = (fail_inc >= {1'b0, failure_limit_reg});

    // first digit sits in the top nibble; digits past the passcode read as zero
    for (genvar i = 0; i < CODE_DIGITS; i++)
    begin : g_want
        localparam int SHIFT = 4 * (CODE_DIGITS - 1 - i);
        if (SHIFT + DIGIT_W <= PASSCODE_W)
        begin : g_in
            assign want[i] = passcode_reg[SHIFT +: DIGIT_W];
        end
        else
        begin : g_out
            assign want[i] = '0;
        end
    end

    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            if (slot_reg[i] != want[i])
                match = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LOCK_IDLE:
            begin
                if (is_start)
                    state_next = LOCK_ENTRY;
            end
            LOCK_ENTRY:
            begin
                if (is_submit || (is_digit && entry_full))
                    state_next = LOCK_IDLE;
            end
            default: state_next = LOCK_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and result
    // ------------------------------------------------------------------
    always_comb
    begin
        position_next = position_reg;
        failures_next = failures_reg;
        for (int i = 0; i < CODE_DIGITS; i++)
            slot_next[i] = slot_reg[i];
        res_next            = '0;
        res_next.status     = STATUS_IGNORED;

        case (state_reg)
            LOCK_IDLE:
            begin
                if (is_start)
                begin
                    position_next   = '0;
                    res_next.status = STATUS_STARTED;
                end
            end
            LOCK_ENTRY:
            begin
                if (is_digit)
                begin
                    // digits beyond the slots only advance the position
                    for (int i = 0; i < CODE_DIGITS; i++)
                    begin
                        if (i < MAX_ENTRY_DIGITS && position_reg == POS_W'(i))
                            slot_next[i] = s1_item_reg.digit;
                    end
                    if (entry_full)
                    begin
                        position_next   = '0;
                        res_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        position_next   = pos_inc;
                        res_next.status = STATUS_DIGIT;
                    end
                end
                else if (is_submit)
                begin
                    position_next = '0;
                    if (match)
                    begin
                        res_next.status = STATUS_GRANTED;
                        res_next.unlock = 1'b1;
                        failures_next   = '0;
                    end
                    else
                    begin
                        res_next.alarm = 1'b1;
                        if (limit_hit)
                        begin
                            res_next.status = STATUS_LOCKOUT;
                            failures_next   = '0;
                        end
                        else
                        begin
                            res_next.status     = STATUS_DENIED;
                            res_next.tries_left = failure_limit_reg - fail_inc[LIMIT_W-1:0];
                            failures_next       = fail_inc[LIMIT_W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= LOCK_IDLE;
            position_reg <= '0;
            failures_reg <= '0;
            for (int i = 0; i < CODE_DIGITS; i++)
                slot_reg[i] <= SLOT_RESET;
        end
        else if (advance)
        begin
            state_reg    <= state_next;
            position_reg <= position_next;
            failures_reg <= failures_next;
            for (int i = 0; i < CODE_DIGITS; i++)
                slot_reg[i] <= slot_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_pos_below_max, clk, rst_n, position_reg < MAX_POS,
                   "position reached max")
    `ASSERT_IMPLY(a_idle_pos_zero, clk, rst_n, state_reg == LOCK_IDLE,
                  position_reg == '0, "idle with nonzero position")
    `ASSERT_ALWAYS(a_failures_bound, clk, rst_n, failures_reg != {LIMIT_W{1'b1}},
                   "failure count overflow")
    `ASSERT_IMPLY(a_grant_clears, clk, rst_n, res_valid_reg && res_reg.unlock,
                  failures_reg == '0 && state_reg == LOCK_IDLE,
                  "grant left failures or entry")
    `ASSERT_IMPLY(a_lockout_clears, clk, rst_n,
                  res_valid_reg && res_reg.status == STATUS_LOCKOUT,
                  failures_reg == '0, "lockout left failures")

endmodule

`default_nettype wire

/* bench/keypad_code_lock_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_tb
// Self-checking bench for the keypad code lock. Key items go in through the
// stall handshake. A built-in model of the lock state, digit slots, failure
// count and register copies predicts one response per accepted item. Each
// response is checked field by field in arrival order. The run covers
// directed keys, register extremes, four sender/receiver idling mixes, a long
// output hold-off and a pause with the lock drained.
// ----------------------------------------------------------------------------
module keypad_code_lock_tb;

    import kcl_pkg::*;

    localparam int SLOT_COUNT     = 6;
    localparam int ENTRY_MAX      = 7;
    localparam int RESULT_LATENCY = 2;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int PRINT_CAP      = 30;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  key_valid;
    logic                  key_stall;
    key_item_t             key;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_item_t             res;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [PASSCODE_W-1:0] cfg_data;

    // model of the lock
    logic [PASSCODE_W-1:0] code_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    lock_state_t           lock_mode;
    int                    entry_pos;
    logic [DIGIT_W-1:0]    slot_digit [SLOT_COUNT];
    logic [LIMIT_W-1:0]    fail_count;

    res_item_t lock_results_due[$];

    int error_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int cycle_count    = 0;
    int send_gap_pct   = 0;
    int stall_pct      = 0;
    int hold_off_left  = 0;
    int status_seen [8];

    keypad_code_lock dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key       (key),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, lock_results_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: hold off while the counter runs, else stall at random
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            res_stall <= 1'b1;
            hold_off_left--;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_CAP)
            $display("Mismatch at response %0d: %s got %0d, want %0d",
                     results_seen, what, got, want);
        error_count++;
    endtask

    function automatic res_item_t next_lock_result(input key_item_t k);
        res_item_t r;
        int        next_fails;
        bit        match;
        r        = '0;
        r.status = STATUS_IGNORED;
        case (k.kind)
            KIND_START:
            begin
                if (lock_mode == LOCK_IDLE)
                begin
                    lock_mode = LOCK_ENTRY;
                    entry_pos = 0;
                    r.status  = STATUS_STARTED;
                end
            end
            KIND_DIGIT:
            begin
                if (lock_mode == LOCK_ENTRY)
                begin
                    // digits past the slots only advance the position
                    if (entry_pos < SLOT_COUNT)
                        slot_digit[entry_pos] = k.digit;
                    entry_pos++;
                    if (entry_pos >= ENTRY_MAX)
                    begin
                        lock_mode = LOCK_IDLE;
                        entry_pos = 0;
                        r.status  = STATUS_FULL;
                    end
                    else
                    begin
                        r.status = STATUS_DIGIT;
                    end
                end
            end
            KIND_SUBMIT:
            begin
                if (lock_mode == LOCK_ENTRY)
                begin
                    match = 1'b1;
                    for (int i = 0; i < SLOT_COUNT; i++)
                        if (slot_digit[i] != code_reg[4*(SLOT_COUNT-1-i) +: 4])
                            match = 1'b0;
                    if (match)
                    begin
                        r.status   = STATUS_GRANTED;
                        r.unlock   = 1'b1;
                        fail_count = '0;
                    end
                    else
                    begin
                        next_fails = int'(fail_count) + 1;
                        r.alarm    = 1'b1;
                        if (next_fails >= int'(limit_reg))
                        begin
                            r.status   = STATUS_LOCKOUT;
                            fail_count = '0;
                        end
                        else
                        begin
                            r.status     = STATUS_DENIED;
                            r.tries_left = LIMIT_W'(int'(limit_reg) - next_fails);
                            fail_count   = LIMIT_W'(next_fails);
                        end
                    end
                    lock_mode = LOCK_IDLE;
                    entry_pos = 0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Predict at every accepted key item
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && key_valid === 1'b1 && key_stall === 1'b0)
            lock_results_due.push_back(next_lock_result(key));
    end

    // Check every accepted response against the oldest prediction
    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            results_seen++;
            if (lock_results_due.size() == 0)
            begin
                report_mismatch("unexpected response, status", int'(res.status), -1);
            end
            else
            begin
                want = lock_results_due.pop_front();
                status_seen[want.status]++;
                if (res.status !== want.status)
                    report_mismatch("status", int'(res.status), int'(want.status));
                if (res.tries_left !== want.tries_left)
                    report_mismatch("tries_left", int'(res.tries_left),
                                    int'(want.tries_left));
                if (res.unlock !== want.unlock)
                    report_mismatch("unlock", int'(res.unlock), int'(want.unlock));
                if (res.alarm !== want.alarm)
                    report_mismatch("alarm", int'(res.alarm), int'(want.alarm));
            end
        end
    end

    task automatic press_key(input logic [1:0] kind, input logic [DIGIT_W-1:0] digit);
        key_item_t k;
        int        gap;
        k.kind  = kind;
        k.digit = digit;
        @(negedge clk);
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            key_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        key       <= k;
        key_valid <= 1'b1;
        @(posedge clk);
        while (key_stall !== 1'b0)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        key_valid <= 1'b0;
        while (lock_results_due.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [PASSCODE_W-1:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        if (idx == REG_PASSCODE)
            code_reg = value;
        else
            limit_reg = value[LIMIT_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One entry: start, a run of digits close to the code, then submit (a run that fills the entry may skip it)
    task automatic send_attempt();
        bit                 good;
        int                 n;
        int                 bad_pos;
        logic [DIGIT_W-1:0] d;
        good    = ($urandom_range(99) < 45);
        n       = ($urandom_range(99) < 70) ? SLOT_COUNT : $urandom_range(0, ENTRY_MAX);
        bad_pos = $urandom_range(0, SLOT_COUNT - 1);
        press_key(KIND_START, DIGIT_W'($urandom_range(0, 15)));
        for (int i = 0; i < n; i++)
        begin
            if (i < SLOT_COUNT)
                d = code_reg[4*(SLOT_COUNT-1-i) +: 4];
            else
                d = DIGIT_W'($urandom_range(0, 9));
            if (!good && i == bad_pos)
                d = DIGIT_W'($urandom_range(0, 15));
            // stray start inside an entry now and then
            if ($urandom_range(99) < 4)
                press_key(KIND_START, '0);
            press_key(KIND_DIGIT, d);
        end
        if (n < ENTRY_MAX || $urandom_range(99) < 30)
            press_key(KIND_SUBMIT, DIGIT_W'($urandom_range(0, 15)));
    endtask

    task automatic send_traffic(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 12)
                press_key(2'($urandom_range(0, 3)), DIGIT_W'($urandom_range(0, 15)));
            else
                send_attempt();
        end
    endtask

    task automatic load_random_settings();
        logic [PASSCODE_W-1:0] code;
        for (int i = 0; i < SLOT_COUNT; i++)
            code[4*i +: 4] = DIGIT_W'($urandom_range(0, 9));
        write_register(REG_PASSCODE, code);
        if ($urandom_range(99) < 80)
            write_register(REG_FAILURE_LIMIT, PASSCODE_W'($urandom_range(1, 5)));
        else
            write_register(REG_FAILURE_LIMIT, PASSCODE_W'($urandom_range(6, 15)));
    endtask

    task automatic test_directed_keys();
        // keys while idle, and the unused kind
        press_key(KIND_SUBMIT, 4'd0);
        press_key(KIND_DIGIT, 4'd9);
        press_key(2'd3, 4'd15);
        // correct reset code, with a second start ignored
        press_key(KIND_START, 4'd0);
        press_key(KIND_START, 4'd0);
        press_key(KIND_DIGIT, 4'd1);
        press_key(KIND_DIGIT, 4'd7);
        press_key(KIND_DIGIT, 4'd8);
        press_key(KIND_DIGIT, 4'd5);
        press_key(KIND_DIGIT, 4'd0);
        press_key(KIND_DIGIT, 4'd9);
        press_key(KIND_SUBMIT, 4'd0);
        // digit above nine in the first slot
        press_key(KIND_START, 4'd0);
        press_key(KIND_DIGIT, 4'd15);
        press_key(KIND_SUBMIT, 4'd0);
        // seven digits close the entry; the seventh is not stored
        press_key(KIND_START, 4'd0);
        repeat (SLOT_COUNT) press_key(KIND_DIGIT, 4'd0);
        press_key(KIND_DIGIT, 4'd9);
        press_key(KIND_SUBMIT, 4'd0);
        wait_for_results();
    endtask

    task automatic test_register_extremes();
        // all-zero code matches the slots left by the full entry
        write_register(REG_PASSCODE, 24'h000000);
        write_register(REG_FAILURE_LIMIT, 24'd1);
        press_key(KIND_START, 4'd0);
        press_key(KIND_SUBMIT, 4'd0);
        wait_for_results();
        write_register(REG_PASSCODE, 24'h999999);
        write_register(REG_FAILURE_LIMIT, 24'd15);
        press_key(KIND_START, 4'd0);
        press_key(KIND_SUBMIT, 4'd0);
        wait_for_results();
        // drop the limit to the current count: next denial locks out
        write_register(REG_FAILURE_LIMIT, 24'd1);
        press_key(KIND_START, 4'd0);
        press_key(KIND_SUBMIT, 4'd0);
        press_key(KIND_START, 4'd0);
        repeat (SLOT_COUNT) press_key(KIND_DIGIT, 4'd9);
        press_key(KIND_SUBMIT, 4'd0);
        wait_for_results();
    endtask

    task automatic test_idle_mix(input int gap_pct, input int hold_pct, input int count);
        load_random_settings();
        send_gap_pct = gap_pct;
        stall_pct    = hold_pct;
        send_traffic(count);
        wait_for_results();
    endtask

    task automatic test_output_hold_off();
        load_random_settings();
        send_gap_pct = 0;
        stall_pct    = 0;
        @(posedge clk);
        hold_off_left = 80;
        send_traffic(50);
        wait_for_results();
        // sender idles with everything drained, then resumes
        send_traffic(30);
        wait_for_results();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        key_valid = 1'b0;
        key       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        code_reg  = PASSCODE_RESET;
        limit_reg = LIMIT_RESET;
        lock_mode = LOCK_IDLE;
        entry_pos = 0;
        fail_count = '0;
        foreach (slot_digit[i]) slot_digit[i] = SLOT_RESET;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_keys();
        test_register_extremes();
        test_idle_mix(0, 0, 300);
        test_idle_mix(45, 0, 300);
        test_idle_mix(0, 45, 300);
        test_idle_mix(33, 33, 300);
        test_output_hold_off();

        repeat (RESULT_LATENCY + 8) @(posedge clk);
        if (lock_results_due.size() != 0)
            report_mismatch("responses never arrived", 0, lock_results_due.size());
        $display("Sent %0d key items, checked %0d responses in %0d cycles.",
                 items_sent, results_seen, cycle_count);
        $display("Seen: %0d granted, %0d denied, %0d lockouts, %0d full entries.",
                 status_seen[STATUS_GRANTED], status_seen[STATUS_DENIED],
                 status_seen[STATUS_LOCKOUT], status_seen[STATUS_FULL]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
